// ===== design/fcps_pkg.sv =====
// ----------------------------------------------------------------------------
// fcps_pkg
// Shared widths, percent limits, register indexes and bundle types for the
// fan curve and pwm select block.
// ----------------------------------------------------------------------------
package fcps_pkg;

  localparam int TEMP_W     = 12;
  localparam int PCT_W      = 7;
  localparam int COUNT_W    = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [PCT_W-1:0]   PCT_MIN       = 7'd20;
  localparam logic [PCT_W-1:0]   PCT_COLD      = 7'd30;
  localparam logic [PCT_W-1:0]   PCT_WARM      = 7'd66;
  localparam logic [PCT_W-1:0]   PCT_DEFAULT   = 7'd90;
  localparam logic [PCT_W-1:0]   PCT_HOT       = 7'd100;
  localparam logic [PCT_W-1:0]   PCT_DRIVE_MAX = 7'd99;
  localparam logic [COUNT_W-1:0] COUNT_PERIOD  = 10'd800;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AUTO_MODE      = 2'd0,
    CFG_MANUAL_PERCENT = 2'd1
  } cfg_index_t;

  typedef struct packed {
    logic                     auto_mode;
    logic [PCT_W-1:0]         manual_percent;
  } cfg_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] reject_temp;
    logic                     reject_valid;
    logic signed [TEMP_W-1:0] case_temp;
    logic                     case_valid;
  } sample_t;

  typedef struct packed {
    logic [PCT_W-1:0]         fan_percent;
    logic [PCT_W-1:0]         drive_percent;
    logic [COUNT_W-1:0]       compare_count;
  } result_t;

endpackage

// ===== design/fcps_duty.sv =====
// ----------------------------------------------------------------------------
// fcps_duty
// Curve evaluation for both sensors, mode select, drive clamp and compare
// count, all combinational from the registered sample.
// ----------------------------------------------------------------------------
module fcps_duty
  import fcps_pkg::*;
(
  input  sample_t sample,
  input  cfg_t    cfg,
  output result_t result
);

  // reject curve: warm 640, hot 880
  // floor(9t/160) = floor((9t>>5)/5), /5 as *205>>10
  // floor(17d/120) = floor((17d>>3)/15), /15 as *1093>>14
  function automatic logic [PCT_W-1:0] reject_curve(input logic signed [TEMP_W-1:0] t);
    logic [7:0]  d;
    logic [11:0] p17;
    logic [19:0] q15;
    logic [9:0]  tu;
    logic [12:0] p9;
    logic [15:0] q5;
    d   = 8'(t - 12'sd640);
    p17 = {4'b0, d} * 12'd17;
    q15 = {11'b0, p17[11:3]} * 20'd1093;
    tu  = t[9:0];
    p9  = {3'b0, tu} * 13'd9;
    q5  = {8'b0, p9[12:5]} * 16'd205;
    if (t > 12'sd880) begin
      reject_curve = PCT_HOT;
    end else if (t > 12'sd640) begin
      reject_curve = PCT_WARM + {1'b0, q15[19:14]};
    end else if (t > 12'sd0) begin
      reject_curve = PCT_COLD + {1'b0, q5[15:10]};
    end else begin
      reject_curve = PCT_COLD;
    end
  endfunction

  // case curve: warm 800, hot 1040
  // floor(9t/200) = floor((9t>>3)/25), /25 as *164>>12
  function automatic logic [PCT_W-1:0] case_curve(input logic signed [TEMP_W-1:0] t);
    logic [7:0]  d;
    logic [11:0] p17;
    logic [19:0] q15;
    logic [9:0]  tu;
    logic [12:0] p9;
    logic [17:0] q25;
    d   = 8'(t - 12'sd800);
    p17 = {4'b0, d} * 12'd17;
    q15 = {11'b0, p17[11:3]} * 20'd1093;
    tu  = t[9:0];
    p9  = {3'b0, tu} * 13'd9;
    q25 = {8'b0, p9[12:3]} * 18'd164;
    if (t > 12'sd1040) begin
      case_curve = PCT_HOT;
    end else if (t > 12'sd800) begin
      case_curve = PCT_WARM + {1'b0, q15[19:14]};
    end else if (t > 12'sd0) begin
      case_curve = PCT_COLD + {1'b0, q25[17:12]};
    end else begin
      case_curve = PCT_COLD;
    end
  endfunction

  logic [PCT_W-1:0] reject_pct;
  logic [PCT_W-1:0] case_pct;
  logic [PCT_W-1:0] auto_pct;
  logic [PCT_W-1:0] pct;
  logic [PCT_W-1:0] drive;

  always_comb begin
    reject_pct = reject_curve(sample.reject_temp);
    case_pct   = case_curve(sample.case_temp);

    // no valid reject reading starts from the default duty
    auto_pct = sample.reject_valid ? reject_pct : PCT_DEFAULT;
    if (sample.case_valid && (case_pct > auto_pct)) begin
      auto_pct = case_pct;
    end

    if (cfg.auto_mode) begin
      pct = auto_pct;
    end else if (cfg.manual_percent < PCT_MIN) begin
      pct = PCT_MIN;
    end else if (cfg.manual_percent > PCT_HOT) begin
      pct = PCT_HOT;
    end else begin
      pct = cfg.manual_percent;
    end

    if (pct > PCT_DRIVE_MAX) begin
      drive = PCT_DRIVE_MAX;
    end else if (pct < PCT_MIN) begin
      drive = PCT_MIN;
    end else begin
      drive = pct;
    end

    result.fan_percent   = pct;
    result.drive_percent = drive;
    result.compare_count = COUNT_PERIOD - {drive, 3'b000};
  end

endmodule

// ===== design/fan_curve_pwm_select.sv =====
// ----------------------------------------------------------------------------
// fan_curve_pwm_select
// Fan duty selection from two temperature readings with an inverted pwm
// compare count; auto curve or manual percent.
// ----------------------------------------------------------------------------
// datapath: an accepted request passes one input register and one result
// register; done is raised with the result as it is loaded
// throughput: one request per cycle, busy stays low, results cannot stall
// config writes complete in the cycle they are presented (cfg_ready high)
// reset: synchronous rst clears the pipeline valids, auto_mode to 0 and
// manual_percent to 90
module fan_curve_pwm_select
  import fcps_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [TEMP_W-1:0] reject_temp,
  input  logic                     reject_valid,
  input  logic signed [TEMP_W-1:0] case_temp,
  input  logic                     case_valid,
  output logic                     done,
  output logic [PCT_W-1:0]         fan_percent,
  output logic [PCT_W-1:0]         drive_percent,
  output logic [COUNT_W-1:0]       compare_count,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data
);

  cfg_t    cfg;
  sample_t sample;
  logic    sample_vld;
  result_t result_next;
  result_t result;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.auto_mode      <= 1'b0;
      cfg.manual_percent <= PCT_DEFAULT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_AUTO_MODE:      cfg.auto_mode      <= cfg_data[0];
        CFG_MANUAL_PERCENT: cfg.manual_percent <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_vld <= 1'b0;
    end else begin
      sample_vld <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      sample.reject_temp  <= reject_temp;
      sample.reject_valid <= reject_valid;
      sample.case_temp    <= case_temp;
      sample.case_valid   <= case_valid;
    end
  end

  fcps_duty u_duty (
    .sample (sample),
    .cfg    (cfg),
    .result (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sample_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_vld) begin
      result <= result_next;
    end
  end

  assign fan_percent   = result.fan_percent;
  assign drive_percent = result.drive_percent;
  assign compare_count = result.compare_count;

endmodule

// ===== design/fcps_check.sv =====
// ----------------------------------------------------------------------------
// fcps_check
// Port-level checks on request timing and result consistency, bound to the
// top level.
// ----------------------------------------------------------------------------
module fcps_check
  import fcps_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     start,
  input logic                     busy,
  input logic                     done,
  input logic [PCT_W-1:0]         fan_percent,
  input logic [PCT_W-1:0]         drive_percent,
  input logic [COUNT_W-1:0]       compare_count
);

  // every accepted request yields a result, flagged by done
  a_req_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("accepted request produced no result");

  // no result without a request
  a_done_req: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result without a matching request");

  // drive clamp follows the chosen percent
  a_drive_clamp: assert property (@(posedge clk) disable iff (rst)
    done |-> (fan_percent <= PCT_HOT) && (drive_percent >= PCT_MIN) &&
             (drive_percent <= PCT_DRIVE_MAX) &&
             (((fan_percent < PCT_MIN) || (fan_percent > PCT_DRIVE_MAX)) ||
              (drive_percent == fan_percent)))
    else $error("drive percent inconsistent with fan percent");

  // compare count is the inverted drive
  a_count: assert property (@(posedge clk) disable iff (rst)
    done |-> (compare_count == (COUNT_PERIOD - {drive_percent, 3'b000})))
    else $error("compare count mismatch");

endmodule

bind fan_curve_pwm_select fcps_check u_fcps_check (.*);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for fan_curve_pwm_select: a short stimulus table with
// hand-typed results at the corners, then random configuration phases with
// bursty requests, the other results compared against an in-bench duty predictor.
// ----------------------------------------------------------------------------
module testbench;
  import fcps_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  localparam int REJECT_WARM_T = 640;
  localparam int REJECT_HOT_T  = 880;
  localparam int CASE_WARM_T   = 800;
  localparam int CASE_HOT_T    = 1040;
  localparam int RANDOM_ITEMS  = 1880;

  typedef struct {
    logic       auto_mode;
    logic [6:0] manual_percent;
    sample_t    item;
    logic       typed;
    result_t    want;
  } stim_row_t;

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic signed [TEMP_W-1:0] reject_temp;
  logic                     reject_valid;
  logic signed [TEMP_W-1:0] case_temp;
  logic                     case_valid;
  logic                     done;
  logic [PCT_W-1:0]         fan_percent;
  logic [PCT_W-1:0]         drive_percent;
  logic [COUNT_W-1:0]       compare_count;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_DATA_W-1:0]    cfg_data;

  cfg_t      fan_cfg;
  result_t   duty_q[$];
  int        errors = 0;
  logic      typed_on;
  result_t   typed_res;
  stim_row_t stim_tbl[$];

  fan_curve_pwm_select DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .reject_temp  (reject_temp),
    .reject_valid (reject_valid),
    .case_temp    (case_temp),
    .case_valid   (case_valid),
    .done         (done),
    .fan_percent  (fan_percent),
    .drive_percent(drive_percent),
    .compare_count(compare_count),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAIL fan_curve_pwm_select");
    $finish;
  end

  // three-segment curve, floor division on 1/16 C readings
  function automatic int curve_percent(int t, int warm, int hot);
    if (t > hot) return int'(PCT_HOT);
    if (t > warm)
      return int'(PCT_WARM) + ((int'(PCT_HOT) - int'(PCT_WARM)) * (t - warm)) / (hot - warm);
    if (t > 0) return int'(PCT_COLD) + ((int'(PCT_WARM) - int'(PCT_COLD)) * t) / warm;
    return int'(PCT_COLD);
  endfunction

  function automatic result_t predict_duty(cfg_t c, sample_t s);
    int      pct;
    int      drive;
    int      case_pct;
    result_t r;
    if (c.auto_mode) begin
      pct = int'(PCT_DEFAULT);
      if (s.reject_valid)
        pct = curve_percent(int'($signed(s.reject_temp)), REJECT_WARM_T, REJECT_HOT_T);
      if (s.case_valid) begin
        case_pct = curve_percent(int'($signed(s.case_temp)), CASE_WARM_T, CASE_HOT_T);
        if (case_pct > pct) pct = case_pct;
      end
    end else begin
      pct = int'(c.manual_percent);
      if (pct < int'(PCT_MIN)) pct = int'(PCT_MIN);
      if (pct > int'(PCT_HOT)) pct = int'(PCT_HOT);
    end
    drive = pct;
    if (drive > int'(PCT_DRIVE_MAX)) drive = int'(PCT_DRIVE_MAX);
    if (drive < int'(PCT_MIN)) drive = int'(PCT_MIN);
    r.fan_percent   = pct[PCT_W-1:0];
    r.drive_percent = drive[PCT_W-1:0];
    r.compare_count = COUNT_W'(int'(COUNT_PERIOD) - (int'(COUNT_PERIOD) * drive) / 100);
    return r;
  endfunction

  function automatic stim_row_t mk_row(bit am, int mp, int rt, bit rv, int ct, bit cv,
                                       bit typed = 0, int f = 0, int d = 0, int c = 0);
    stim_row_t row;
    row.auto_mode          = am;
    row.manual_percent     = mp[6:0];
    row.item.reject_temp   = rt[TEMP_W-1:0];
    row.item.reject_valid  = rv;
    row.item.case_temp     = ct[TEMP_W-1:0];
    row.item.case_valid    = cv;
    row.typed              = typed;
    row.want.fan_percent   = f[PCT_W-1:0];
    row.want.drive_percent = d[PCT_W-1:0];
    row.want.compare_count = c[COUNT_W-1:0];
    return row;
  endfunction

  // one in five near a curve breakpoint, two in five across 0 to 1100, the rest wider
  function automatic logic signed [TEMP_W-1:0] rand_temp();
    int t;
    case ($urandom_range(0, 4))
      0: t = $urandom_range(0, 4095) - 2048;
      1: t = $urandom_range(0, 3072) - 1040;
      2: begin
        case ($urandom_range(0, 4))
          0: t = 0;
          1: t = REJECT_WARM_T;
          2: t = REJECT_HOT_T;
          3: t = CASE_WARM_T;
          default: t = CASE_HOT_T;
        endcase
        t = t + $urandom_range(0, 8) - 4;
      end
      default: t = $urandom_range(0, 1100);
    endcase
    return t[TEMP_W-1:0];
  endfunction

  function automatic sample_t rand_sample();
    sample_t s;
    s.reject_temp  = rand_temp();
    s.reject_valid = 1'($urandom_range(0, 1));
    s.case_temp    = rand_temp();
    s.case_valid   = 1'($urandom_range(0, 1));
    return s;
  endfunction

  // scoreboard: config shadow, request capture and result check
  always @(posedge clk) begin : mon
    result_t want;
    if (rst) begin
      fan_cfg.auto_mode      = 1'b0;
      fan_cfg.manual_percent = PCT_DEFAULT;
      duty_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_AUTO_MODE:      fan_cfg.auto_mode = cfg_data[0];
          CFG_MANUAL_PERCENT: fan_cfg.manual_percent = cfg_data;
          default: ;
        endcase
      end
      if (done) begin
        if (duty_q.size() == 0) begin
          $display("%0t: unexpected result fan %0d drive %0d count %0d",
                   $time, fan_percent, drive_percent, compare_count);
          errors++;
        end else begin
          want = duty_q.pop_front();
          if (fan_percent !== want.fan_percent) begin
            $display("%0t: fan_percent expected %0d got %0d",
                     $time, want.fan_percent, fan_percent);
            errors++;
          end
          if (drive_percent !== want.drive_percent) begin
            $display("%0t: drive_percent expected %0d got %0d",
                     $time, want.drive_percent, drive_percent);
            errors++;
          end
          if (compare_count !== want.compare_count) begin
            $display("%0t: compare_count expected %0d got %0d",
                     $time, want.compare_count, compare_count);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        if (typed_on) duty_q.push_back(typed_res);
        else duty_q.push_back(predict_duty(fan_cfg, '{reject_temp, reject_valid,
                                                      case_temp, case_valid}));
      end
    end
  end

  task automatic send_request(input sample_t s, input logic typed, input result_t res);
    reject_temp  <= s.reject_temp;
    reject_valid <= s.reject_valid;
    case_temp    <= s.case_temp;
    case_valid   <= s.case_valid;
    typed_on     <= typed;
    typed_res    <= res;
    start        <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (duty_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_config(input logic am, input logic [6:0] mp, input bit spare);
    logic [CFG_DATA_W-1:0] mode_word;
    drain();
    mode_word    = CFG_DATA_W'($urandom);
    mode_word[0] = am;
    // a write to an unused index must leave both registers alone
    if (spare) write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                         CFG_DATA_W'($urandom));
    if ($urandom_range(0, 1)) begin
      write_reg(CFG_AUTO_MODE, mode_word);
      write_reg(CFG_MANUAL_PERCENT, mp);
    end else begin
      write_reg(CFG_MANUAL_PERCENT, mp);
      write_reg(CFG_AUTO_MODE, mode_word);
    end
    if (spare) write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                         CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  initial begin : stim
    logic       cur_am;
    logic [6:0] cur_mp;
    logic [6:0] mp;
    int         sent;
    int         phase_len;
    int         burst_left;
    int         gap;
    int         pct_edges[9];

    pct_edges    = '{0, 19, 20, 21, 98, 99, 100, 101, 127};
    rst          = 1'b1;
    start        = 1'b0;
    reject_temp  = '0;
    reject_valid = 1'b0;
    case_temp    = '0;
    case_valid   = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    typed_on     = 1'b0;
    typed_res    = '0;

    //                       mode  pct  reject     case    typed result
    stim_tbl.push_back(mk_row(0,  90,    0, 0,     0, 0, 1,  90, 90,  80)); // reset values
    stim_tbl.push_back(mk_row(0,   0,  100, 1,   100, 1, 1,  20, 20, 640));
    stim_tbl.push_back(mk_row(0,  19,  -50, 1,  2047, 1, 1,  20, 20, 640));
    stim_tbl.push_back(mk_row(0,  20,  900, 1,   900, 1));
    stim_tbl.push_back(mk_row(0, 100,    0, 0,     0, 0, 1, 100, 99,   8));
    stim_tbl.push_back(mk_row(0, 127,    0, 1,     0, 1, 1, 100, 99,   8));
    stim_tbl.push_back(mk_row(0,  55, 2047, 1, -2048, 1, 1,  55, 55, 360));
    // auto curve: no sensor valid falls back to the default percent
    stim_tbl.push_back(mk_row(1,  55, 2047, 0, -2048, 0, 1,  90, 90,  80));
    stim_tbl.push_back(mk_row(1,  55, -2048, 1, 2047, 0, 1,  30, 30, 560));
    stim_tbl.push_back(mk_row(1,  55,    0, 1,     0, 0, 1,  30, 30, 560));
    stim_tbl.push_back(mk_row(1,  55,    1, 1,     0, 0));
    stim_tbl.push_back(mk_row(1,  55,  640, 1,     0, 0, 1,  66, 66, 272));
    stim_tbl.push_back(mk_row(1,  55,  641, 1,     0, 0));
    stim_tbl.push_back(mk_row(1,  55,  880, 1,     0, 0, 1, 100, 99,   8));
    stim_tbl.push_back(mk_row(1,  55,  881, 1,     0, 0, 1, 100, 99,   8));
    stim_tbl.push_back(mk_row(1,  55, 2047, 1,     0, 0, 1, 100, 99,   8));
    stim_tbl.push_back(mk_row(1,  55,  320, 1,     0, 0));
    // case sensor alone competes with the default percent
    stim_tbl.push_back(mk_row(1,  55,    0, 0,     0, 1, 1,  90, 90,  80));
    stim_tbl.push_back(mk_row(1,  55,    0, 0,  1040, 1, 1, 100, 99,   8));
    stim_tbl.push_back(mk_row(1,  55,    0, 0,  1000, 1));
    stim_tbl.push_back(mk_row(1,  55,  100, 1,  2047, 1, 1, 100, 99,   8));
    stim_tbl.push_back(mk_row(1,  55, -2048, 1, -2048, 1, 1, 30, 30, 560));
    stim_tbl.push_back(mk_row(1,  55,  700, 1,   900, 1));
    stim_tbl.push_back(mk_row(1,  55,  800, 1,   800, 1));

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    cur_am = 1'b0;
    cur_mp = PCT_DEFAULT;
    foreach (stim_tbl[i]) begin
      if (stim_tbl[i].auto_mode != cur_am || stim_tbl[i].manual_percent != cur_mp) begin
        cur_am = stim_tbl[i].auto_mode;
        cur_mp = stim_tbl[i].manual_percent;
        apply_config(cur_am, cur_mp, 1'b0);
      end
      send_request(stim_tbl[i].item, stim_tbl[i].typed, stim_tbl[i].want);
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) mp = 7'(pct_edges[$urandom_range(0, 8)]);
      else mp = 7'($urandom_range(0, 127));
      apply_config($urandom_range(0, 9) < 7, mp, $urandom_range(0, 3) == 0);
      phase_len  = $urandom_range(40, 160);
      if (phase_len > RANDOM_ITEMS - sent) phase_len = RANDOM_ITEMS - sent;
      burst_left = $urandom_range(1, 24);
      repeat (phase_len) begin
        send_request(rand_sample(), 1'b0, '0);
        sent++;
        burst_left--;
        if (burst_left == 0) begin
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
          if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
          end
          // now and then a long unbroken stretch
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                   : $urandom_range(1, 24);
        end
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("PASS fan_curve_pwm_select");
    end else begin
      $display("FAIL fan_curve_pwm_select");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/fcps_pkg.sv
design/fcps_duty.sv
design/fan_curve_pwm_select.sv
design/fcps_check.sv
verif/testbench.sv
